// ----- hdl/pending_request_table_with_timeout_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the pending request table
// Shared same-cycle and next-cycle implication forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef PENDING_REQUEST_TABLE_WITH_TIMEOUT_MACROS_SVH
`define PENDING_REQUEST_TABLE_WITH_TIMEOUT_MACROS_SVH

// same-cycle implication
`define PRT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pending request table: check failed");

// next-cycle implication
`define PRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pending request table: check failed");

`endif

// ----- hdl/prt_pkg.sv -----
// ----------------------------------------------------------------------------
// prt_pkg
// Types, codes and helpers shared by the pending request table modules.
// ----------------------------------------------------------------------------
`default_nettype none

package prt_pkg;

   localparam int SLOTS  = 32;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int REQ_W  = 192;
   localparam int RSP_W  = 112;

   typedef logic [SLOT_W-1:0] slot_type;
   typedef logic [SLOTS-1:0]  vec_type;

   // action codes
   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_LOOKUP = 2'd1;
   localparam logic [1:0] ACT_REMOVE = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_MISS = 2'd2;

   // request item, last field in the low bits
   typedef struct packed {
      logic [4:0]  pad;
      logic [31:0] now_ms;
      logic [30:0] life_ms;
      logic [15:0] client_tag;
      logic [31:0] conn_serial;
      logic [19:0] conn_handle;
      logic [21:0] worker_key;
      logic [31:0] stream_key;
      logic [1:0]  action;
   } req_type;

   // result item, last field in the low bits
   typedef struct packed {
      logic [4:0]  pad;
      logic [31:0] found_expiry;
      logic [15:0] found_client_tag;
      logic [31:0] found_conn_serial;
      logic [19:0] found_conn_handle;
      logic [4:0]  slot_index;
      logic [1:0]  status;
   } rsp_type;

   // stored connection record, read back on a lookup hit
   typedef struct packed {
      logic [31:0] expiry;
      logic [15:0] client;
      logic [31:0] serial;
      logic [19:0] handle;
   } rec_type;

   // controller -> datapath
   typedef struct packed {
      logic load_req;
      logic eval;
      logic commit;
      logic load_out;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_free;
   } sts_type;

   // lowest set bit: {found, index}
   function automatic logic [SLOT_W:0] first_set(input vec_type vec);
      logic [SLOT_W:0] res;
      res = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (vec[i]) begin
            res = {1'b1, SLOT_W'(i)};
         end
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/pending_request_table_with_timeout.sv -----
// Flow: one item in flight; each walks accept, compare, commit and reply, and its
//   result shows on rsp_ from the reply step. A new item is taken only after the reply.
//   The reply step waits until the previous result has left or leaves in the reply
//   cycle; the controller walks the four steps once per item.
// Reset: synchronous, active high; clears every valid bit, the sequencer and the
//   result valid flag. Stored keys and records need no clearing.
// ----------------------------------------------------------------------------
// pending_request_table_with_timeout
// Table of outstanding requests keyed by stream and worker id, with expiry
// reaping on insert, lookup of the stored connection record and remove.
// ----------------------------------------------------------------------------
`default_nettype none

module pending_request_table_with_timeout (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // request item
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   // low to high: action[2], stream_key[32], worker_key[22], conn_handle[20],
   //   conn_serial[32], client_tag[16], life_ms[31], now_ms[32], zero pad[5]
   input  wire logic [prt_pkg::REQ_W-1:0] req_tdata,
   // result item
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   // low to high: status[2], slot_index[5], found_conn_handle[20],
   //   found_conn_serial[32], found_client_tag[16], found_expiry[32], zero pad[5]
   output logic [prt_pkg::RSP_W-1:0]      rsp_tdata
);
   import prt_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequencer: one item in flight; reply waits on a free output register
   prt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // slot cells compare all keys and expiries at once; lowest free or lowest
   // matching slot is picked in the commit step
   prt_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

// ----- hdl/prt_ctrl.sv -----
// ----------------------------------------------------------------------------
// prt_ctrl
// Sequencer: accept, evaluate, commit, reply.
// ----------------------------------------------------------------------------
`default_nettype none

module prt_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire prt_pkg::sts_type sts,
   output prt_pkg::cmd_type      cmd
);
   import prt_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_EVAL   = 4'b0010,
      S_COMMIT = 4'b0100,
      S_REPLY  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in     = state_ff;
      req_tready   = 1'b0;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            req_tready   = 1'b1;
            cmd.load_req = req_tvalid;
            if (req_tvalid) state_in = S_EVAL;
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = S_REPLY;
         end
         S_REPLY: begin
            // hold until the output register can take the result
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

`default_nettype wire

// ----- hdl/prt_datapath.sv -----
// ----------------------------------------------------------------------------
// prt_datapath
// Slot table, parallel key/expiry compare, slot select and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module prt_datapath (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire prt_pkg::cmd_type           cmd,
   output prt_pkg::sts_type                sts,
   input  wire logic [prt_pkg::REQ_W-1:0]  req_tdata,
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic [prt_pkg::RSP_W-1:0]       rsp_tdata
);
   import prt_pkg::*;

   req_type     req;
   logic [1:0]  action_ff;
   logic [31:0] stream_key_ff, now_ff;
   logic [21:0] worker_key_ff;
   logic [30:0] timeout_ff;
   rec_type     new_rec_ff;

   // per-slot key and expiry cells, compared in parallel
   vec_type     valid_ff, valid_in;
   logic [31:0] stream_ff [SLOTS];
   logic [21:0] worker_ff [SLOTS];
   logic [31:0] expiry_ff [SLOTS];

   // connection records
   rec_type     pay_mem [SLOTS];
   rec_type     rd_ff;

   vec_type     match_ff, match_in, expired_ff, expired_in;
   vec_type     live;
   logic [SLOT_W:0] free_sel, hit_sel;
   logic        write_en;
   logic [31:0] new_expiry;

   slot_type    sel_ff, sel_in;
   logic [1:0]  status_ff, status_in;
   logic        lookup_hit_ff, lookup_hit_in;

   logic        rsp_valid_ff;
   rsp_type     rsp_ff, rsp_in;

   assign req = req_type'(req_tdata);

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         action_ff         <= req.action;
         stream_key_ff     <= req.stream_key;
         worker_key_ff     <= req.worker_key;
         timeout_ff        <= req.life_ms;
         now_ff            <= req.now_ms;
         new_rec_ff.handle <= req.conn_handle;
         new_rec_ff.serial <= req.conn_serial;
         new_rec_ff.client <= req.client_tag;
         new_rec_ff.expiry <= '0;
      end
   end

   // compare stage
   always_comb begin
      logic [31:0] diff;
      diff = '0;
      for (int i = 0; i < SLOTS; i++) begin
         diff          = now_ff - expiry_ff[i];
         expired_in[i] = valid_ff[i] && (diff != 32'd0) && !diff[31];
         match_in[i]   = valid_ff[i] && (stream_ff[i] == stream_key_ff)
                         && (worker_ff[i] == worker_key_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         match_ff   <= match_in;
         expired_ff <= expired_in;
      end
   end

   // commit stage
   assign live       = valid_ff & ~expired_ff;
   assign free_sel   = first_set(~live);
   assign hit_sel    = first_set(match_ff);
   assign new_expiry = now_ff + {1'b0, timeout_ff};

   always_comb begin
      valid_in      = valid_ff;
      sel_in        = '0;
      status_in     = ST_MISS;
      lookup_hit_in = 1'b0;
      write_en      = 1'b0;
      case (action_ff)
         ACT_INSERT: begin
            valid_in  = live;   // reaped entries stay freed even when full
            status_in = ST_FULL;
            if (free_sel[SLOT_W]) begin
               valid_in[free_sel[SLOT_W-1:0]] = 1'b1;
               write_en  = 1'b1;
               sel_in    = free_sel[SLOT_W-1:0];
               status_in = ST_OK;
            end
         end
         ACT_LOOKUP: begin
            if (hit_sel[SLOT_W]) begin
               sel_in        = hit_sel[SLOT_W-1:0];
               status_in     = ST_OK;
               lookup_hit_in = 1'b1;
            end
         end
         ACT_REMOVE: begin
            if (hit_sel[SLOT_W]) begin
               valid_in[hit_sel[SLOT_W-1:0]] = 1'b0;
               sel_in    = hit_sel[SLOT_W-1:0];
               status_in = ST_OK;
            end
         end
         default: begin
            status_in = ST_MISS;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.commit) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         sel_ff        <= sel_in;
         status_ff     <= status_in;
         lookup_hit_ff <= lookup_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && write_en) begin
         stream_ff[free_sel[SLOT_W-1:0]] <= stream_key_ff;
         worker_ff[free_sel[SLOT_W-1:0]] <= worker_key_ff;
         expiry_ff[free_sel[SLOT_W-1:0]] <= new_expiry;
      end
   end

   // record memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.commit && write_en) begin
         pay_mem[free_sel[SLOT_W-1:0]] <= '{expiry: new_expiry,
                                            client: new_rec_ff.client,
                                            serial: new_rec_ff.serial,
                                            handle: new_rec_ff.handle};
      end
      if (cmd.commit) begin
         rd_ff <= pay_mem[hit_sel[SLOT_W-1:0]];
      end
   end

   // result register
   always_comb begin
      rsp_in        = '0;
      rsp_in.status = status_ff;
      if (status_ff == ST_OK) begin
         rsp_in.slot_index = 5'(sel_ff);
      end
      if (lookup_hit_ff) begin
         rsp_in.found_conn_handle = rd_ff.handle;
         rsp_in.found_conn_serial = rd_ff.serial;
         rsp_in.found_client_tag  = rd_ff.client;
         rsp_in.found_expiry      = rd_ff.expiry;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset)                     rsp_valid_ff <= 1'b0;
      else if (cmd.load_out)         rsp_valid_ff <= 1'b1;
      else if (rsp_tready)           rsp_valid_ff <= 1'b0;
   end

   assign sts.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_ff;

endmodule

`default_nettype wire

// ----- hdl/prt_checker.sv -----
// ----------------------------------------------------------------------------
// prt_checker
// Port-level checks on the pending request table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pending_request_table_with_timeout_macros.svh"

module prt_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_tvalid,
   input wire logic                      req_tready,
   input wire logic                      rsp_tvalid,
   input wire logic                      rsp_tready,
   input wire logic [prt_pkg::RSP_W-1:0] rsp_tdata
);
   import prt_pkg::*;

   // stalled result holds
   `PRT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // one item at a time: no accept right after an accept
   `PRT_ASSERT_NEXT(a_one_in_flight, clock, reset, req_tvalid && req_tready, !req_tready)

   // status is always a defined code
   `PRT_ASSERT_NOW(a_status_code, clock, reset, rsp_tvalid, rsp_tdata[1:0] == ST_OK || rsp_tdata[1:0] == ST_FULL || rsp_tdata[1:0] == ST_MISS)

   // full or miss carries no slot and no record
   `PRT_ASSERT_NOW(a_fail_zero, clock, reset, rsp_tvalid && rsp_tdata[1:0] != ST_OK, rsp_tdata[RSP_W-1:2] == '0)

endmodule

bind pending_request_table_with_timeout prt_checker u_prt_checker (.*);

`default_nettype wire
